@@ rtl/i2cms_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared constants for the I2C master bit sequencer: command codes, phase
// counts and the configuration register map.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // Command codes on the op field. The same codes name the command in progress.
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_START   = 3'd1;
  localparam logic [2:0] OP_RESTART = 3'd2;
  localparam logic [2:0] OP_STOP    = 3'd3;
  localparam logic [2:0] OP_WRITE   = 3'd4;
  localparam logic [2:0] OP_READ    = 3'd5;
  localparam logic [2:0] CMD_IDLE   = 3'd0;

  // Phase counts per command.
  localparam logic [4:0] START_PHASES = 5'd4;
  localparam logic [4:0] STOP_PHASES  = 5'd3;
  localparam logic [4:0] BYTE_PHASES  = 5'd27;
  // First phase of the acknowledge slot in a byte command.
  localparam logic [4:0] ACK_PHASE    = 5'd24;

  localparam logic [7:0] MSB_MASK = 8'h80;

  // Configuration register map.
  localparam int          PADDR_W              = 2;
  localparam logic [1:0]  REG_PHASE_TICKS_ADDR = 2'd0;
  localparam logic [15:0] PHASE_TICKS_RESET    = 16'd1;

endpackage

@@ rtl/i2c_master_bit_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_unit
// A result is registered and presented in the cycle after its item is accepted.
// Throughput: one item per cycle; a new item enters in the same cycle that the
// previous result is taken, so only a stalled result slows intake.
// Reset (rst, synchronous): both lines released high, no command in progress,
// phase_ticks = 1, no result pending.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_unit (
  input  logic                            clk,
  input  logic                            rst,
  // Item channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      op,
  input  logic [7:0]                      wr_byte,
  input  logic                            send_nack,
  input  logic                            sda_in,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            scl_out,
  output logic                            sda_out,
  output logic                            sda_listen,
  output logic                            busy_res,
  output logic                            done_res,
  output logic [7:0]                      rx_byte,
  output logic                            ack_level,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [i2cms_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [15:0] phase_ticks;

  logic [2:0]  command_kind, command_kind_next;
  logic [4:0]  phase_index, phase_index_next;
  logic [1:0]  sub_phase, sub_phase_next;
  logic [3:0]  bit_counter, bit_counter_next;
  logic [7:0]  shift_register, shift_register_next;
  logic [15:0] tick_counter, tick_counter_next;
  logic        scl_level, scl_level_next;
  logic        sda_level, sda_level_next;
  logic        listen_mode, listen_mode_next;
  logic        nack_choice, nack_choice_next;
  logic        ack_seen, ack_seen_next;
  logic [7:0]  received_byte, received_byte_next;
  logic        done_next;

  logic        in_xfer;
  logic        do_enter;
  logic [4:0]  enter_ph;
  logic [1:0]  enter_sub;
  logic [16:0] tick_sum;
  logic [16:0] tick_limit;
  logic [4:0]  phase_total;
  logic        ack_slot;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == i2cms_pkg::REG_PHASE_TICKS_ADDR) ? {16'd0, phase_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= i2cms_pkg::PHASE_TICKS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == i2cms_pkg::REG_PHASE_TICKS_ADDR) begin
      phase_ticks <= pwdata[15:0];
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign tick_sum   = {1'b0, tick_counter} + 17'd1;
  // A zero phase length behaves as one tick per phase.
  assign tick_limit = (phase_ticks == 16'd0) ? 17'd1 : {1'b0, phase_ticks};

  always_comb begin
    unique case (command_kind) inside
      i2cms_pkg::OP_START, i2cms_pkg::OP_RESTART: phase_total = i2cms_pkg::START_PHASES;
      i2cms_pkg::OP_STOP:                         phase_total = i2cms_pkg::STOP_PHASES;
      default:                                    phase_total = i2cms_pkg::BYTE_PHASES;
    endcase
  end

  always_comb begin
    command_kind_next   = command_kind;
    phase_index_next    = phase_index;
    sub_phase_next      = sub_phase;
    bit_counter_next    = bit_counter;
    shift_register_next = shift_register;
    tick_counter_next   = tick_counter;
    scl_level_next      = scl_level;
    sda_level_next      = sda_level;
    listen_mode_next    = listen_mode;
    nack_choice_next    = nack_choice;
    ack_seen_next       = ack_seen;
    received_byte_next  = received_byte;
    done_next           = 1'b0;
    do_enter            = 1'b0;
    enter_ph            = 5'd0;
    enter_sub           = 2'd0;
    ack_slot            = 1'b0;

    if (command_kind == i2cms_pkg::CMD_IDLE) begin
      if (op >= i2cms_pkg::OP_START && op <= i2cms_pkg::OP_READ) begin
        command_kind_next = op;
        phase_index_next  = 5'd0;
        sub_phase_next    = 2'd0;
        tick_counter_next = 16'd0;
        bit_counter_next  = 4'd0;
        if (op == i2cms_pkg::OP_WRITE) begin
          shift_register_next = wr_byte;
        end
        if (op == i2cms_pkg::OP_READ) begin
          shift_register_next = 8'd0;
          nack_choice_next    = send_nack;
          listen_mode_next    = 1'b1;
          sda_level_next      = 1'b1;
        end
        do_enter = 1'b1;
      end
    end else if (op == i2cms_pkg::OP_TICK) begin
      tick_counter_next = tick_sum[15:0];
      if (tick_sum >= tick_limit) begin
        tick_counter_next = 16'd0;
        // Sampling happens at the end of an SCL-high phase of a byte command.
        if ((command_kind == i2cms_pkg::OP_WRITE || command_kind == i2cms_pkg::OP_READ) &&
            sub_phase == 2'd1) begin
          if (phase_index >= i2cms_pkg::ACK_PHASE) begin
            if (command_kind == i2cms_pkg::OP_WRITE) begin
              ack_seen_next = sda_in;
            end
          end else if (command_kind == i2cms_pkg::OP_READ) begin
            shift_register_next = {shift_register[6:0], sda_in};
            bit_counter_next    = bit_counter + 4'd1;
          end
        end
        phase_index_next = phase_index + 5'd1;
        sub_phase_next   = (sub_phase == 2'd2) ? 2'd0 : sub_phase + 2'd1;
        if (phase_index_next >= phase_total) begin
          if (command_kind == i2cms_pkg::OP_READ) begin
            received_byte_next = shift_register_next;
          end
          command_kind_next = i2cms_pkg::CMD_IDLE;
          phase_index_next  = 5'd0;
          sub_phase_next    = 2'd0;
          done_next         = 1'b1;
        end else begin
          do_enter = 1'b1;
        end
      end
    end

    // Apply the line levels of the phase being entered.
    if (do_enter) begin
      enter_ph  = phase_index_next;
      enter_sub = sub_phase_next;
      ack_slot  = enter_ph >= i2cms_pkg::ACK_PHASE;
      unique case (command_kind_next)
        i2cms_pkg::OP_START: begin
          case (enter_ph[1:0])
            2'd0:    scl_level_next = 1'b1;
            2'd1:    sda_level_next = 1'b1;
            2'd2:    sda_level_next = 1'b0;
            default: scl_level_next = 1'b0;
          endcase
        end
        i2cms_pkg::OP_RESTART: begin
          case (enter_ph[1:0])
            2'd0:    sda_level_next = 1'b1;
            2'd1:    scl_level_next = 1'b1;
            2'd2:    sda_level_next = 1'b0;
            default: scl_level_next = 1'b0;
          endcase
        end
        i2cms_pkg::OP_STOP: begin
          case (enter_ph[1:0])
            2'd0:    sda_level_next = 1'b0;
            2'd1:    scl_level_next = 1'b1;
            default: sda_level_next = 1'b1;
          endcase
        end
        default: begin
          if (enter_sub == 2'd1) begin
            scl_level_next = 1'b1;
          end else if (enter_sub == 2'd2) begin
            scl_level_next = 1'b0;
            if (ack_slot && command_kind_next == i2cms_pkg::OP_WRITE) begin
              listen_mode_next = 1'b0;
            end
          end else begin
            scl_level_next = 1'b0;
            if (ack_slot) begin
              if (command_kind_next == i2cms_pkg::OP_WRITE) begin
                sda_level_next   = 1'b1;
                listen_mode_next = 1'b1;
              end else begin
                listen_mode_next = 1'b0;
                sda_level_next   = nack_choice_next;
              end
            end else if (command_kind_next == i2cms_pkg::OP_WRITE) begin
              sda_level_next      = |(shift_register_next & i2cms_pkg::MSB_MASK);
              shift_register_next = {shift_register_next[6:0], 1'b0};
              bit_counter_next    = bit_counter_next + 4'd1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_kind   <= i2cms_pkg::CMD_IDLE;
      phase_index    <= 5'd0;
      sub_phase      <= 2'd0;
      bit_counter    <= 4'd0;
      shift_register <= 8'd0;
      tick_counter   <= 16'd0;
      scl_level      <= 1'b1;
      sda_level      <= 1'b1;
      listen_mode    <= 1'b0;
      nack_choice    <= 1'b0;
      ack_seen       <= 1'b0;
      received_byte  <= 8'd0;
      out_valid      <= 1'b0;
    end else begin
      if (in_xfer) begin
        command_kind   <= command_kind_next;
        phase_index    <= phase_index_next;
        sub_phase      <= sub_phase_next;
        bit_counter    <= bit_counter_next;
        shift_register <= shift_register_next;
        tick_counter   <= tick_counter_next;
        scl_level      <= scl_level_next;
        sda_level      <= sda_level_next;
        listen_mode    <= listen_mode_next;
        nack_choice    <= nack_choice_next;
        ack_seen       <= ack_seen_next;
        received_byte  <= received_byte_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register; its contents only matter while out_valid is high.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      scl_out    <= scl_level_next;
      sda_out    <= sda_level_next;
      sda_listen <= listen_mode_next;
      busy_res   <= command_kind_next != i2cms_pkg::CMD_IDLE;
      done_res   <= done_next;
      rx_byte    <= received_byte_next;
      ack_level  <= ack_seen_next;
    end
  end

endmodule

@@ rtl/i2cms_checker.sv @@
// ----------------------------------------------------------------------------
// i2cms_checker
// Port-level checks for the I2C master bit sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module i2cms_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl_out,
  input logic       sda_out,
  input logic       sda_listen,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] rx_byte,
  input logic       ack_level
);

  // Nothing is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // Every accepted item produces a result in the next cycle.
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transfer produced no result");

  // A finished command leaves the sequencer idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  // A stalled result keeps its contents.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(scl_out) && $stable(sda_out) &&
    $stable(sda_listen) && $stable(busy_res) && $stable(done_res) &&
    $stable(rx_byte) && $stable(ack_level))
    else $error("stalled result changed");

endmodule

bind i2c_master_bit_sequencer_unit i2cms_checker u_i2cms_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .scl_out    (scl_out),
  .sda_out    (sda_out),
  .sda_listen (sda_listen),
  .busy_res   (busy_res),
  .done_res   (done_res),
  .rx_byte    (rx_byte),
  .ack_level  (ack_level)
);
